// ===== hdl/fcc_pkg.sv =====
// Shared types, widths and helpers of the FAN corridor compressor.
package fcc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int RUN_BITS    = 14;
  localparam int TOL_BITS    = 15;
  // Corridor bounds must hold diff +/- tolerance without overflow.
  localparam int BOUND_BITS  = (SAMPLE_BITS + 2 > TOL_BITS + 2) ? SAMPLE_BITS + 2 : TOL_BITS + 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(8);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] point_value;
    logic        [RUN_BITS-1:0]    run_length;
    logic                          final_pair;
  } out_item_t;

  // One or two results caused by one input item; the second is always final.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic        [RUN_BITS-1:0]    run_first;
    logic                          first_final;
    logic                          has_second;
    logic        [RUN_BITS-1:0]    run_second;
  } fcc_cmd_t;

  function automatic logic [RUN_BITS-1:0] sat_inc(input logic [RUN_BITS-1:0] r);
    sat_inc = (&r) ? r : r + RUN_BITS'(1);
  endfunction

endpackage

// ===== hdl/fcc_front.sv =====
// Front end: accepts samples, tracks the corridor and queues result commands.
module fcc_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  fcc_pkg::in_item_t                     in_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fcc_pkg::TOL_BITS-1:0]          cfg_data,
  input  logic                                  q_full,
  output logic                                  push,
  output fcc_pkg::fcc_cmd_t                     push_cmd
);

  localparam int SB = fcc_pkg::SAMPLE_BITS;
  localparam int RB = fcc_pkg::RUN_BITS;
  localparam int BB = fcc_pkg::BOUND_BITS;
  localparam int TB = fcc_pkg::TOL_BITS;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_RUN    = 3'b100
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [TB-1:0]         tol_r;
  logic signed [SB-1:0]  prev_r, prev_nxt;
  logic signed [BB-1:0]  upper_r, upper_nxt;
  logic signed [BB-1:0]  lower_r, lower_nxt;
  logic [RB-1:0]         run_r, run_nxt;

  logic                  acc;
  logic                  last;
  logic signed [SB:0]    diff;
  logic signed [BB-1:0]  diff_ext;
  logic signed [BB-1:0]  tol_ext;
  logic signed [BB-1:0]  hi;
  logic signed [BB-1:0]  lo;
  logic                  outside;
  logic [RB-1:0]         run_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign acc       = in_valid & ~q_full;
  assign last      = in_data.end_of_stream;

  assign diff     = {in_data.sample[SB-1], in_data.sample} - {prev_r[SB-1], prev_r};
  assign diff_ext = BB'(diff);
  assign tol_ext  = $signed({{(BB-TB){1'b0}}, tol_r});
  assign hi       = diff_ext + tol_ext;
  assign lo       = diff_ext - tol_ext;
  assign outside  = (diff_ext < lower_r) || (diff_ext > upper_r);
  assign run_inc  = fcc_pkg::sat_inc(run_r);

  always_comb begin
    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    upper_nxt = upper_r;
    lower_nxt = lower_r;
    run_nxt   = run_r;
    push      = 1'b0;
    push_cmd.value       = in_data.sample;
    push_cmd.run_first   = '0;
    push_cmd.first_final = 1'b0;
    push_cmd.has_second  = 1'b0;
    push_cmd.run_second  = RB'(1);
    if (acc) begin
      prev_nxt = in_data.sample;
      case (phase_r)
        PH_SECOND: begin
          upper_nxt = hi;
          lower_nxt = lo;
          run_nxt   = RB'(1);
          phase_nxt = PH_RUN;
          if (last) begin
            push                 = 1'b1;
            push_cmd.run_first   = fcc_pkg::sat_inc(RB'(1));
            push_cmd.first_final = 1'b1;
            phase_nxt            = PH_FIRST;
          end
        end
        PH_RUN: begin
          if (outside) begin
            // break: emit the segment end and reopen around this difference
            push               = 1'b1;
            push_cmd.run_first = run_inc;
            upper_nxt          = hi;
            lower_nxt          = lo;
            run_nxt            = '0;
            if (last) begin
              push_cmd.has_second = 1'b1;
              phase_nxt           = PH_FIRST;
            end
          end else begin
            // narrow the corridor
            if (lo > lower_r) lower_nxt = lo;
            if (hi < upper_r) upper_nxt = hi;
            run_nxt = run_inc;
            if (last) begin
              push                 = 1'b1;
              push_cmd.run_first   = fcc_pkg::sat_inc(run_inc);
              push_cmd.first_final = 1'b1;
              phase_nxt            = PH_FIRST;
            end
          end
        end
        default: begin
          run_nxt              = '0;
          push                 = 1'b1;
          push_cmd.run_first   = '0;
          push_cmd.first_final = last;
          phase_nxt            = last ? PH_FIRST : PH_SECOND;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      tol_r   <= fcc_pkg::TOL_RESET;
      prev_r  <= '0;
      upper_r <= '0;
      lower_r <= '0;
      run_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      upper_r <= upper_nxt;
      lower_r <= lower_nxt;
      run_r   <= run_nxt;
      if (cfg_valid) begin
        tol_r <= cfg_data;
      end
    end
  end

endmodule

// ===== hdl/fcc_queue.sv =====
// Short command queue between the front end and the result stage.
module fcc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fcc_pkg::fcc_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output fcc_pkg::fcc_cmd_t head,
  output logic              empty
);

  localparam int DEPTH = fcc_pkg::QUEUE_DEPTH;
  localparam int PB    = fcc_pkg::QPTR_BITS;
  localparam int CB    = fcc_pkg::QCNT_BITS;

  fcc_pkg::fcc_cmd_t   slots_r [DEPTH];
  logic [PB-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CB-1:0]       count_r, count_nxt;

  assign full  = (count_r == CB'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CB'(1);
    if (pop && !push) count_nxt = count_r - CB'(1);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == PB'(DEPTH - 1)) ? '0 : wr_ptr_r + PB'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PB'(DEPTH - 1)) ? '0 : rd_ptr_r + PB'(1);
    end
  end

endmodule

// ===== hdl/fcc_back.sv =====
// Result stage: expands queued commands into one or two output items.
module fcc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  fcc_pkg::fcc_cmd_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output fcc_pkg::out_item_t out_data
);

  localparam int SB = fcc_pkg::SAMPLE_BITS;
  localparam int RB = fcc_pkg::RUN_BITS;

  logic                 out_valid_r, out_valid_nxt;
  fcc_pkg::out_item_t   out_data_r, out_data_nxt;
  logic                 sec_pend_r, sec_pend_nxt;
  logic signed [SB-1:0] sec_val_r, sec_val_nxt;
  logic [RB-1:0]        sec_run_r, sec_run_nxt;
  logic                 load;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sec_pend_nxt  = sec_pend_r;
    sec_val_nxt   = sec_val_r;
    sec_run_nxt   = sec_run_r;
    pop           = 1'b0;
    if (load) begin
      if (sec_pend_r) begin
        // finish the pending final item before the next command
        out_valid_nxt           = 1'b1;
        out_data_nxt.point_value = sec_val_r;
        out_data_nxt.run_length  = sec_run_r;
        out_data_nxt.final_pair  = 1'b1;
        sec_pend_nxt            = 1'b0;
      end else if (!empty) begin
        pop                      = 1'b1;
        out_valid_nxt            = 1'b1;
        out_data_nxt.point_value = head.value;
        out_data_nxt.run_length  = head.run_first;
        out_data_nxt.final_pair  = head.first_final;
        sec_pend_nxt             = head.has_second;
        sec_val_nxt              = head.value;
        sec_run_nxt              = head.run_second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    sec_val_r  <= sec_val_nxt;
    sec_run_r  <= sec_run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_pend_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_pend_r  <= sec_pend_nxt;
    end
  end

endmodule

// ===== hdl/fan_corridor_compressor.sv =====
// FAN corridor ECG compressor: input sample channel, result channel, tolerance port.
//
// in_valid/in_stall/in_data carry one signed sample per item plus an end flag.
// An item is taken on a clock edge with in_valid high and in_stall low.
// out_valid/out_stall/out_data carry (point_value, run_length, final_pair)
// items; the receiver holds out_stall high to keep the current item in place.
// cfg_valid/cfg_data write the 15-bit tolerance; cfg_ready is always high.
// Write it only while no item is in flight.
// Throughput: one sample per cycle while in_stall is low. A sample that emits a
// result has its command registered into a four-entry queue, and the result
// stage then registers the output item that appears on out_data.
// A break on the final sample emits two items, one after the other.
// in_stall rises only when the queue is full, which happens when the receiver stalls.
// Synchronous reset (rst_n low) empties the queue and output, restores the
// tolerance to 8 and starts a new record at the next sample.
module fan_corridor_compressor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fcc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fcc_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fcc_pkg::TOL_BITS-1:0]  cfg_data
);

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  fcc_pkg::fcc_cmd_t q_push_cmd;
  fcc_pkg::fcc_cmd_t q_head;

  fcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (q_push),
    .push_cmd  (q_push_cmd)
  );

  fcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  fcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
